FILE: sv/srto_pkg.sv
package srto_pkg;

  localparam int MAX_SECTIONS_DEF = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int ADDR_W     = 32;
  localparam int SLOT_W     = 4;

  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 40;

  localparam logic [4:0] SECTION_COUNT_RST = 5'd0;
  localparam logic [4:0] ALIGN_LOG2_RST    = 5'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECTION_COUNT = 1'b0,
    REG_ALIGN_LOG2    = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  // microcode addresses
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DISPATCH = 3'd1,
    ST_LOAD     = 3'd2,
    ST_QSTART   = 3'd3,
    ST_WALK     = 3'd4,
    ST_DRAIN1   = 3'd5,
    ST_DRAIN2   = 3'd6,
    ST_FIN      = 3'd7
  } step_t;

  typedef enum logic [2:0] {
    C_NEVER      = 3'd0,
    C_ALWAYS     = 3'd1,
    C_NO_ACCEPT  = 3'd2,
    C_IS_LOAD    = 3'd3,
    C_EMPTY      = 3'd4,
    C_MORE       = 3'd5,
    C_OUT_BUSY   = 3'd6
  } cond_t;

  typedef struct packed {
    logic  in_rdy;
    logic  q_init;
    logic  mem_wr;
    logic  rd_issue;
    logic  out_load;
    cond_t cond;
    step_t jump;
    step_t next;
  } ctrl_word_t;

  typedef struct packed {
    logic in_acc;
    logic is_load;
    logic empty;
    logic more;
    logic out_busy;
  } seq_status_t;

  function automatic ctrl_word_t rom_word(input step_t step);
    ctrl_word_t w;
    w = '{in_rdy: 1'b0, q_init: 1'b0, mem_wr: 1'b0, rd_issue: 1'b0, out_load: 1'b0,
          cond: C_NEVER, jump: ST_IDLE, next: ST_IDLE};
    unique case (step)
      ST_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = C_NO_ACCEPT;
        w.jump   = ST_IDLE;
        w.next   = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        w.q_init = 1'b1;
        w.cond   = C_IS_LOAD;
        w.jump   = ST_LOAD;
        w.next   = ST_QSTART;
      end
      ST_LOAD: begin
        w.mem_wr = 1'b1;
        w.cond   = C_ALWAYS;
        w.jump   = ST_FIN;
      end
      ST_QSTART: begin
        w.cond = C_EMPTY;
        w.jump = ST_FIN;
        w.next = ST_WALK;
      end
      ST_WALK: begin
        w.rd_issue = 1'b1;
        w.cond     = C_MORE;
        w.jump     = ST_WALK;
        w.next     = ST_DRAIN1;
      end
      ST_DRAIN1: begin
        w.next = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        w.next = ST_FIN;
      end
      ST_FIN: begin
        w.out_load = 1'b1;
        w.cond     = C_OUT_BUSY;
        w.jump     = ST_FIN;
        w.next     = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/srto_seq.sv
module srto_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srto_pkg::seq_status_t status,
  output srto_pkg::ctrl_word_t  ctrl
);

  srto_pkg::step_t step_r;
  srto_pkg::step_t step_nxt;
  logic            take;

  assign ctrl = srto_pkg::rom_word(step_r);

  always_comb begin
    unique case (ctrl.cond)
      srto_pkg::C_NEVER:     take = 1'b0;
      srto_pkg::C_ALWAYS:    take = 1'b1;
      srto_pkg::C_NO_ACCEPT: take = !status.in_acc;
      srto_pkg::C_IS_LOAD:   take = status.is_load;
      srto_pkg::C_EMPTY:     take = status.empty;
      srto_pkg::C_MORE:      take = status.more;
      srto_pkg::C_OUT_BUSY:  take = status.out_busy;
      default:               take = 1'b0;
    endcase
    step_nxt = take ? ctrl.jump : ctrl.next;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= srto_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: sv/section_rva_to_file_offset.sv
// Channel | Dir | Handshake          | Payload
// in_     | in  | tvalid/tready      | tuser: mode; tdata: slot, start, vsize, raw, rsize, addr
// out_    | out | tvalid/tready      | tdata: found, file_offset
// cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// A load writes its slot of the section table. A query walks count entries,
// count = min(section_count, MAX_SECTIONS), none when count is 0: the walk
// reads one entry per cycle from the section table through a three-stage
// compare pipeline. rst_n is synchronous; the table itself is not cleared.
// A new transaction is taken while a result waits in the output register;
// the sequencer holds in its final step until that register is free.
module section_rva_to_file_offset #(
  parameter int MAX_SECTIONS = srto_pkg::MAX_SECTIONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] mode
  input  logic                                in_tuser,
  // [3:0] entry_index, [35:4] section_start, [67:36] section_virtual_size,
  // [99:68] section_raw_offset, [131:100] section_raw_size,
  // [163:132] query_address, [167:164] zero
  input  logic [srto_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] found, [32:1] file_offset, [39:33] zero
  output logic [srto_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [srto_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srto_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
  localparam int AW    = srto_pkg::ADDR_W;

  srto_pkg::ctrl_word_t  ctrl;
  srto_pkg::seq_status_t status;

  logic in_acc;

  // config
  logic [4:0] section_count_r;
  logic [4:0] align_log2_r;

  // captured transaction
  logic                          is_load_r;
  logic [srto_pkg::SLOT_W-1:0]   slot_r;
  logic [AW-1:0]                 start_r;
  logic [AW-1:0]                 vsize_r;
  logic [AW-1:0]                 raw_r;
  logic                          has_raw_r;
  logic [AW-1:0]                 addr_r;

  // section table; raw offset kept as raw - start
  logic [AW-1:0] mem_start [MAX_SECTIONS];
  logic [AW-1:0] mem_size  [MAX_SECTIONS];
  logic [AW-1:0] mem_delta [MAX_SECTIONS];
  logic          mem_has   [MAX_SECTIONS];

  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] cnt;
  logic             slot_ok;

  logic          v0_r;
  logic [AW-1:0] rd_start_r;
  logic [AW-1:0] rd_size_r;
  logic [AW-1:0] rd_delta_r;
  logic          rd_has_r;

  logic          v1_r;
  logic [AW-1:0] s1_start_r;
  logic [AW-1:0] s1_align_r;
  logic [AW-1:0] s1_off_r;
  logic          s1_ge_r;
  logic          s1_has_r;

  logic [AW-1:0] mask;
  logic [AW:0]   end_sum;
  logic          hit;

  logic [AW-1:0] offset_r;
  logic          stop_r;

  logic          out_valid_r;
  logic [AW-1:0] out_off_r;
  logic          out_found_r;
  logic          out_ld;

  srto_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  assign in_tready = ctrl.in_rdy;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (32'(section_count_r) > 32'(MAX_SECTIONS)) begin
      cnt = CNT_W'(MAX_SECTIONS);
    end else begin
      cnt = CNT_W'(section_count_r);
    end
  end

  assign slot_ok = 32'(slot_r) < 32'(MAX_SECTIONS);

  assign status.in_acc   = in_acc;
  assign status.is_load  = is_load_r;
  assign status.empty    = (cnt == '0);
  assign status.more     = (32'(idx_r) + 32'd1) < 32'(cnt);
  assign status.out_busy = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_count_r <= srto_pkg::SECTION_COUNT_RST;
      align_log2_r    <= srto_pkg::ALIGN_LOG2_RST;
    end else if (cfg_we) begin
      unique case (srto_pkg::cfg_reg_t'(cfg_index))
        srto_pkg::REG_SECTION_COUNT: section_count_r <= cfg_wdata;
        srto_pkg::REG_ALIGN_LOG2:    align_log2_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_load_r <= (srto_pkg::mode_t'(in_tuser) == srto_pkg::MODE_LOAD);
      slot_r    <= in_tdata[3:0];
      start_r   <= in_tdata[35:4];
      vsize_r   <= in_tdata[67:36];
      raw_r     <= in_tdata[99:68];
      has_raw_r <= (in_tdata[131:100] != '0);
      addr_r    <= in_tdata[163:132];
    end
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (ctrl.mem_wr && slot_ok) begin
      mem_start[IDX_W'(slot_r)] <= start_r;
      mem_size[IDX_W'(slot_r)]  <= vsize_r;
      mem_delta[IDX_W'(slot_r)] <= raw_r - start_r;
      mem_has[IDX_W'(slot_r)]   <= has_raw_r;
    end
    if (ctrl.rd_issue) begin
      rd_start_r <= mem_start[idx_r];
      rd_size_r  <= mem_size[idx_r];
      rd_delta_r <= mem_delta[idx_r];
      rd_has_r   <= mem_has[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
    end else begin
      v0_r <= ctrl.rd_issue;
      v1_r <= v0_r;
      if (ctrl.q_init) begin
        idx_r <= '0;
      end else if (ctrl.rd_issue) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  assign mask = ~({AW{1'b1}} << align_log2_r);

  // stage 1: aligned size, candidate offset, lower bound
  always_ff @(posedge clk) begin
    if (v0_r) begin
      s1_start_r <= rd_start_r;
      s1_align_r <= (rd_size_r + mask) & ~mask;
      s1_off_r   <= addr_r + rd_delta_r;
      s1_ge_r    <= addr_r >= rd_start_r;
      s1_has_r   <= rd_has_r;
    end
  end

  // stage 2: upper bound; a wrapped end never matches
  assign end_sum = {1'b0, s1_start_r} + {1'b0, s1_align_r};
  assign hit     = v1_r && !stop_r && s1_ge_r && !end_sum[AW] && (addr_r < end_sum[AW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      stop_r   <= 1'b0;
    end else if (ctrl.q_init) begin
      offset_r <= '0;
      stop_r   <= 1'b0;
    end else if (hit) begin
      if (!s1_has_r) begin
        offset_r <= '0;
        stop_r   <= 1'b1;
      end else begin
        offset_r <= s1_off_r;
      end
    end
  end

  assign out_ld = ctrl.out_load && !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_off_r   <= offset_r;
      out_found_r <= (offset_r != '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_off_r, out_found_r};

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int MAX_SECT       = srto_pkg::MAX_SECTIONS_DEF;
  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_PHASES     = 8;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } xlat_res_t;

  typedef struct {
    srto_pkg::mode_t mode;
    logic [3:0]      slot;
    logic [31:0]     start;
    logic [31:0]     vsize;
    logic [31:0]     raw;
    logic [31:0]     rsize;
    logic [31:0]     addr;
  } sect_item_t;

  typedef struct {
    row_kind_t  kind;
    sect_item_t it;
    bit         typed;
    xlat_res_t  want;
    logic [4:0] cnt;
    logic [4:0] aln;
  } stim_row_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  srto_pkg::mode_t                 in_tuser   = srto_pkg::MODE_LOAD;
  logic [srto_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [srto_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_we     = 1'b0;
  srto_pkg::cfg_reg_t              cfg_index  = srto_pkg::REG_SECTION_COUNT;
  logic [srto_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  // shadow of the section table and registers
  logic [31:0] tbl_start   [MAX_SECT];
  logic [31:0] tbl_vsize   [MAX_SECT];
  logic [31:0] tbl_raw     [MAX_SECT];
  logic        tbl_has_raw [MAX_SECT];
  logic [4:0]  shadow_count = srto_pkg::SECTION_COUNT_RST;
  logic [4:0]  shadow_align = srto_pkg::ALIGN_LOG2_RST;

  xlat_res_t   expected_xlat[$];
  stim_row_t   dir_rows[$];
  int          err_count      = 0;
  int          idle_cycles    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  int phase_cnt [NUM_PHASES] = '{16, 31, 8, 16, 0, 17, 0, 16};
  int phase_aln [NUM_PHASES] = '{12, 0, 31, 4, 16, 1, 0, 12};
  int phase_len [NUM_PHASES] = '{260, 200, 200, 200, 60, 200, 230, 200};

  section_rva_to_file_offset i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),   // [0] mode
    // [3:0] entry_index, [35:4] section_start, [67:36] section_virtual_size,
    // [99:68] section_raw_offset, [131:100] section_raw_size,
    // [163:132] query_address, [167:164] zero
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] found, [32:1] file_offset, [39:33] zero
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  // Stores loads; walks the table for queries, the last match wins and an
  // entry without raw data stops the walk.
  function automatic xlat_res_t translate_rva(input sect_item_t it);
    xlat_res_t   r;
    logic [31:0] mask;
    logic [31:0] end_a;
    logic [31:0] off;
    int          n;
    int          i;
    bit          stop;
    r    = '0;
    off  = '0;
    stop = 1'b0;
    if (it.mode == srto_pkg::MODE_LOAD) begin
      tbl_start[it.slot]   = it.start;
      tbl_vsize[it.slot]   = it.vsize;
      tbl_raw[it.slot]     = it.raw;
      tbl_has_raw[it.slot] = (it.rsize != 32'd0);
      return r;
    end
    mask = (32'd1 << shadow_align) - 32'd1;
    n    = (int'(shadow_count) > MAX_SECT) ? MAX_SECT : int'(shadow_count);
    for (i = 0; i < n && !stop; i++) begin
      end_a = tbl_start[i] + ((tbl_vsize[i] + mask) & ~mask);
      if (it.addr >= tbl_start[i] && it.addr < end_a) begin
        if (!tbl_has_raw[i]) begin
          off  = '0;
          stop = 1'b1;
        end else begin
          off = it.addr - tbl_start[i] + tbl_raw[i];
        end
      end
    end
    if (off != 32'd0) begin
      r.found  = 1'b1;
      r.offset = off;
    end
    return r;
  endfunction

  function automatic void add_load(input logic [3:0] slot, input logic [31:0] start,
                                   input logic [31:0] vsize, input logic [31:0] raw,
                                   input logic [31:0] rsize);
    stim_row_t row;
    row      = '{kind: ROW_ITEM, typed: 1'b1, want: '0, cnt: '0, aln: '0, it: '{
                 mode: srto_pkg::MODE_LOAD, slot: slot, start: start, vsize: vsize,
                 raw: raw, rsize: rsize, addr: ~start}};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_query(input logic [31:0] addr, input bit typed);
    stim_row_t row;
    row = '{kind: ROW_ITEM, typed: typed, want: '0, cnt: '0, aln: '0, it: '{
            mode: srto_pkg::MODE_QUERY, slot: addr[3:0], start: ~addr, vsize: addr,
            raw: '0, rsize: '1, addr: addr}};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [4:0] cnt, input logic [4:0] aln);
    stim_row_t row;
    row     = '{kind: ROW_CFG, typed: 1'b0, want: '0, cnt: cnt, aln: aln, it: '{
                mode: srto_pkg::MODE_LOAD, slot: '0, start: '0, vsize: '0, raw: '0,
                rsize: '0, addr: '0}};
    dir_rows.push_back(row);
  endfunction

  task automatic send_item(input sect_item_t it, input bit typed, input xlat_res_t want);
    xlat_res_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.mode;
    in_tdata  <= {4'b0, it.addr, it.rsize, it.raw, it.vsize, it.start, it.slot};
    do @(posedge clk); while (!in_tready);
    r = translate_rva(it);
    expected_xlat.push_back(typed ? want : r);
  endtask

  // Registers change only with the block idle and every result collected.
  task automatic program_regs(input logic [4:0] cnt, input logic [4:0] aln);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_xlat.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= srto_pkg::REG_SECTION_COUNT;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_index <= srto_pkg::REG_ALIGN_LOG2;
    cfg_wdata <= aln;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_count = cnt;
    shadow_align = aln;
  endtask

  always @(posedge clk) begin
    xlat_res_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_xlat.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata[32:1], 32'h0);
      end else begin
        w = expected_xlat.pop_front();
        if (out_tdata[0] !== w.found)
          report_mismatch("found", {31'b0, out_tdata[0]}, {31'b0, w.found});
        if (out_tdata[32:1] !== w.offset)
          report_mismatch("file_offset", out_tdata[32:1], w.offset);
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR %0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    sect_item_t  it;
    logic [31:0] mask;
    logic [31:0] span;
    int          ph;
    int          j;
    int          r;

    // with the reset count nothing is searched
    add_query(32'h0000_1000, 1'b1);
    add_load(4'd0, 32'h0000_1000, 32'h0000_0200, 32'h0000_0400, 32'h0000_0200);
    add_load(4'd1, 32'h0000_2000, 32'h0000_1000, 32'h0000_0000, 32'h0000_0000);
    add_load(4'd2, 32'h0000_3000, 32'h0000_0800, 32'h0000_0000, 32'h0000_0100);
    add_load(4'd3, 32'hFFFF_F000, 32'h0000_1000, 32'h0000_8000, 32'h0000_0001);
    add_load(4'd4, 32'h0000_1800, 32'h0000_0100, 32'h0000_9000, 32'h0000_0001);
    add_load(4'd5, 32'h0000_2000, 32'h0000_0010, 32'h0000_5000, 32'h0000_0001);
    add_load(4'd6, 32'h7000_0000, 32'hFFFF_FFFF, 32'h0000_1000, 32'h0000_0001);
    add_load(4'd7, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_load(4'd8, 32'h8000_0000, 32'h7FFF_F000, 32'hFFFF_FFFF, 32'h0000_0001);
    for (j = 9; j < 15; j++)
      add_load(j[3:0], 32'(j) << 16, 32'h0000_1234, 32'(j) << 8, 32'h0000_0010);
    add_load(4'd15, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_cfg(5'd16, 5'd12);
    add_query(32'h0000_1000, 1'b0);
    add_query(32'h0000_1FFF, 1'b0);   // overlap, later entry wins
    add_query(32'h0000_2000, 1'b1);   // entry without raw data stops the walk
    add_query(32'h0000_3000, 1'b1);   // offset comes out zero
    add_query(32'h8000_0001, 1'b1);   // offset wraps to zero
    add_query(32'hFFFF_EFFF, 1'b0);
    add_query(32'h0000_0000, 1'b1);
    add_query(32'hFFFF_FFFF, 1'b1);   // only wrapped-end entries up here
    add_cfg(5'd31, 5'd0);
    add_query(32'h0000_1100, 1'b0);
    add_cfg(5'd2, 5'd31);
    add_query(32'h0000_1100, 1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        program_regs(dir_rows[i].cnt, dir_rows[i].aln);
      end else begin
        send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 6) begin
        program_regs(5'($urandom_range(1, 31)), 5'($urandom_range(0, 31)));
      end else begin
        program_regs(5'(phase_cnt[ph]), 5'(phase_aln[ph]));
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (j = 0; j < phase_len[ph]; j++) begin
        it.mode  = ($urandom_range(0, 3) == 0) ? srto_pkg::MODE_LOAD : srto_pkg::MODE_QUERY;
        it.slot  = 4'($urandom_range(0, 15));
        it.start = $urandom;
        it.vsize = $urandom;
        it.raw   = $urandom;
        it.rsize = $urandom;
        it.addr  = $urandom;
        if (it.mode == srto_pkg::MODE_LOAD) begin
          // mostly compact layouts so that queries keep hitting sections
          if ($urandom_range(0, 4) != 0) begin
            it.start = $urandom_range(0, 255) << $urandom_range(8, 24);
            it.vsize = $urandom_range(0, 32'h1 << $urandom_range(4, 20));
          end
          if ($urandom_range(0, 4) == 0) it.rsize = '0;
        end else begin
          mask = (32'd1 << shadow_align) - 32'd1;
          span = (tbl_vsize[it.slot] + mask) & ~mask;
          r    = $urandom_range(0, 6);
          case (r)
            0: it.addr = tbl_start[it.slot];
            1: it.addr = tbl_start[it.slot] + span - 32'd1;
            2: it.addr = tbl_start[it.slot] + span;
            3: it.addr = tbl_start[it.slot] - 32'd1;
            4: it.addr = $urandom;
            default: it.addr = tbl_start[it.slot] + ((span == 0) ? 32'd0 : $urandom % span);
          endcase
        end
        send_item(it, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_xlat.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_xlat.size() != 0)
      report_mismatch("results still pending", 32'(expected_xlat.size()), 32'h0);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/srto_pkg.sv
sv/srto_seq.sv
sv/section_rva_to_file_offset.sv
tb/sv/tb.sv
